[rtl/sdio_cis_pkg.sv]
// Shared constants and lookup functions for the SDIO CIS tuple chain parser.
package sdio_cis_pkg;

  // Tuple codes
  localparam logic [7:0] CODE_NULL   = 8'h00;
  localparam logic [7:0] CODE_END    = 8'hff;
  localparam logic [7:0] CODE_VERS1  = 8'h15;
  localparam logic [7:0] CODE_MANFID = 8'h20;
  localparam logic [7:0] CODE_FUNCID = 8'h21;
  localparam logic [7:0] CODE_FUNCE  = 8'h22;

  // Extension tuple types
  localparam logic [7:0] EXT_COMMON   = 8'h00;
  localparam logic [7:0] EXT_FUNCTION = 8'h01;
  localparam logic [7:0] EXT_LAN_NODE = 8'h04;

  // Minimum tuple lengths
  localparam logic [7:0] MIN_VERS1     = 8'd3;
  localparam logic [7:0] MIN_MANFID    = 8'd4;
  localparam logic [7:0] MIN_FUNCID    = 8'd2;
  localparam logic [7:0] MIN_FUNCE     = 8'd1;
  localparam logic [7:0] MIN_COMMON    = 8'd4;
  localparam logic [7:0] MIN_LAN_NODE  = 8'd8;
  localparam logic [7:0] MIN_FUNC_V100 = 8'd28;
  localparam logic [7:0] MIN_FUNC_LATE = 8'd42;

  // Data byte positions kept outside the head word
  localparam logic [7:0] POS_BLK_LO = 8'd12;
  localparam logic [7:0] POS_BLK_HI = 8'd13;
  localparam logic [7:0] POS_TMO_LO = 8'd28;
  localparam logic [7:0] POS_TMO_HI = 8'd29;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_KIND  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_FUNCTION_CIS = 2'd0;
  localparam logic [1:0] REG_SDIO_VERSION = 2'd1;
  localparam logic [1:0] REG_DEFAULT_TMO  = 2'd2;

  localparam logic [15:0] DEFAULT_TMO_RESET = 16'd1000;

  // Speed value mantissa, in tenths
  function automatic logic [6:0] speed_mant(input logic [3:0] sel);
    logic [6:0] r;
    unique case (sel)
      4'd0:    r = 7'd0;
      4'd1:    r = 7'd10;
      4'd2:    r = 7'd12;
      4'd3:    r = 7'd13;
      4'd4:    r = 7'd15;
      4'd5:    r = 7'd20;
      4'd6:    r = 7'd25;
      4'd7:    r = 7'd30;
      4'd8:    r = 7'd35;
      4'd9:    r = 7'd40;
      4'd10:   r = 7'd45;
      4'd11:   r = 7'd50;
      4'd12:   r = 7'd55;
      4'd13:   r = 7'd60;
      4'd14:   r = 7'd70;
      default: r = 7'd80;
    endcase
    return r;
  endfunction

  // Speed unit multiplier; reserved units give zero
  function automatic logic [23:0] speed_mult(input logic [2:0] sel);
    logic [23:0] r;
    unique case (sel)
      3'd0:    r = 24'd10000;
      3'd1:    r = 24'd100000;
      3'd2:    r = 24'd1000000;
      3'd3:    r = 24'd10000000;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/sdio_cis_tuple_parser.sv]
// SDIO CIS tuple chain parser: per-byte tuple walk, capture and result register.
//
//  Channel  Direction  Handshake               Payload
//  in       sink       in_valid_i / in_stall_o cis_byte_i, chain_start_i
//  out      source     out_valid_o/out_stall_i status_o and six captured values
//  cfg      APB slave  psel/penable/pready     paddr, pwdata, prdata
//
//  One byte is taken per cycle while in_stall_o is low; the tuple state and
//  captures update at the accepting edge, as does the output register on a
//  chain end. The path is the tuple judge plus one 7x24 speed multiply.
//  Reset clears the parse state and valid flag and presets the config registers.
//  in_stall_o rises only while a held result is stalled downstream.
module sdio_cis_tuple_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cis_byte_i,
  input  logic        chain_start_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] vendor_id_o,
  output logic [15:0] device_id_o,
  output logic [15:0] block_size_o,
  output logic [29:0] max_rate_o,
  output logic [15:0] max_block_size_o,
  output logic [19:0] enable_timeout_ms_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LINK = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // configuration registers
  logic        function_cis_q;
  logic [3:0]  sdio_version_q;
  logic [15:0] default_tmo_q;
  logic        cfg_wr;

  // parse state
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       code_q, code_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       idx_q, idx_d;
  logic [3:0][7:0]  head_q, head_d;
  logic [15:0]      blk_q, blk_d;
  logic [15:0]      tmo_q, tmo_d;

  // captured values
  logic [15:0] vendor_q, vendor_d;
  logic [15:0] device_q, device_d;
  logic [15:0] bsize_q, bsize_d;
  logic [29:0] rate_q, rate_d;
  logic [15:0] mbsize_q, mbsize_d;
  logic [19:0] etmo_q, etmo_d;

  // result register
  logic        out_valid_q;
  logic [1:0]  status_q;

  logic        in_acc;
  logic [1:0]  phase_nx;
  logic        close_tuple;
  logic        end_mark;

  // judge outputs
  logic        jg_go;
  logic [1:0]  jg_status;
  logic        cap_manfid;
  logic        cap_common;
  logic        cap_func;
  logic [7:0]  need_func;
  logic [30:0] rate_prod;
  logic [19:0] tmo_x10;

  logic        emit;
  logic [1:0]  emit_status;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      function_cis_q <= 1'b0;
      sdio_version_q <= '0;
      default_tmo_q  <= sdio_cis_pkg::DEFAULT_TMO_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sdio_cis_pkg::REG_FUNCTION_CIS: function_cis_q <= pwdata[0];
        sdio_cis_pkg::REG_SDIO_VERSION: sdio_version_q <= pwdata[3:0];
        sdio_cis_pkg::REG_DEFAULT_TMO:  default_tmo_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        sdio_cis_pkg::REG_FUNCTION_CIS: prdata = {31'd0, function_cis_q};
        sdio_cis_pkg::REG_SDIO_VERSION: prdata = {28'd0, sdio_version_q};
        sdio_cis_pkg::REG_DEFAULT_TMO:  prdata = {16'd0, default_tmo_q};
        default:                        prdata = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // tuple walk: start clear, then one byte of progress
  always_comb begin
    phase_nx    = chain_start_i ? PH_CODE : phase_q;
    code_d      = chain_start_i ? 8'd0 : code_q;
    len_d       = chain_start_i ? 8'd0 : len_q;
    idx_d       = chain_start_i ? 8'd0 : idx_q;
    head_d      = chain_start_i ? '0 : head_q;
    blk_d       = chain_start_i ? 16'd0 : blk_q;
    tmo_d       = chain_start_i ? 16'd0 : tmo_q;
    close_tuple = 1'b0;
    end_mark    = 1'b0;

    unique case (phase_nx)
      PH_CODE: begin
        if (cis_byte_i == sdio_cis_pkg::CODE_END) begin
          end_mark = 1'b1;
        end else if (cis_byte_i != sdio_cis_pkg::CODE_NULL) begin
          code_d   = cis_byte_i;
          phase_nx = PH_LINK;
        end
      end
      PH_LINK: begin
        if (cis_byte_i == sdio_cis_pkg::CODE_END) begin
          end_mark = 1'b1;
        end else begin
          len_d  = cis_byte_i;
          idx_d  = 8'd0;
          head_d = '0;
          blk_d  = 16'd0;
          tmo_d  = 16'd0;
          if (cis_byte_i == 8'd0) begin
            close_tuple = 1'b1;
          end else begin
            phase_nx = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (idx_d < 8'd4) begin
          head_d[idx_d[1:0]] = head_d[idx_d[1:0]] | cis_byte_i;
        end else if (idx_d == sdio_cis_pkg::POS_BLK_LO) begin
          blk_d[7:0] = cis_byte_i;
        end else if (idx_d == sdio_cis_pkg::POS_BLK_HI) begin
          blk_d[15:8] = cis_byte_i;
        end else if (idx_d == sdio_cis_pkg::POS_TMO_LO) begin
          tmo_d[7:0] = cis_byte_i;
        end else if (idx_d == sdio_cis_pkg::POS_TMO_HI) begin
          tmo_d[15:8] = cis_byte_i;
        end
        if (({1'b0, idx_d} + 9'd1) >= {1'b0, len_d}) begin
          close_tuple = 1'b1;
        end else begin
          idx_d = idx_d + 8'd1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // tuple judge on the completed tuple
  assign rate_prod = {24'd0, sdio_cis_pkg::speed_mant(head_d[3][6:3])}
                   * {7'd0, sdio_cis_pkg::speed_mult(head_d[3][2:0])};
  assign tmo_x10   = {1'b0, tmo_d, 3'd0} + {3'd0, tmo_d, 1'b0};
  assign need_func = (sdio_version_q == 4'd0) ? sdio_cis_pkg::MIN_FUNC_V100
                                              : sdio_cis_pkg::MIN_FUNC_LATE;

  always_comb begin
    jg_go      = 1'b1;
    jg_status  = sdio_cis_pkg::ST_OK;
    cap_manfid = 1'b0;
    cap_common = 1'b0;
    cap_func   = 1'b0;
    unique case (code_d)
      sdio_cis_pkg::CODE_VERS1: begin
        if (len_d < sdio_cis_pkg::MIN_VERS1) begin
          jg_go     = 1'b0;
          jg_status = sdio_cis_pkg::ST_SHORT;
        end
      end
      sdio_cis_pkg::CODE_MANFID: begin
        if (len_d < sdio_cis_pkg::MIN_MANFID) begin
          jg_go     = 1'b0;
          jg_status = sdio_cis_pkg::ST_SHORT;
        end else begin
          cap_manfid = 1'b1;
        end
      end
      sdio_cis_pkg::CODE_FUNCID: begin
        if (len_d < sdio_cis_pkg::MIN_FUNCID) begin
          jg_go     = 1'b0;
          jg_status = sdio_cis_pkg::ST_SHORT;
        end
      end
      sdio_cis_pkg::CODE_FUNCE: begin
        priority if (len_d < sdio_cis_pkg::MIN_FUNCE) begin
          jg_go     = 1'b0;
          jg_status = sdio_cis_pkg::ST_SHORT;
        end else if (head_d[0] == sdio_cis_pkg::EXT_COMMON) begin
          priority if (len_d < sdio_cis_pkg::MIN_COMMON) begin
            jg_go     = 1'b0;
            jg_status = sdio_cis_pkg::ST_SHORT;
          end else if (function_cis_q) begin
            jg_go     = 1'b0;
            jg_status = sdio_cis_pkg::ST_KIND;
          end else begin
            cap_common = 1'b1;
          end
        end else if (head_d[0] == sdio_cis_pkg::EXT_FUNCTION) begin
          priority if (!function_cis_q) begin
            jg_go     = 1'b0;
            jg_status = sdio_cis_pkg::ST_KIND;
          end else if (len_d < need_func) begin
            jg_go     = 1'b0;
            jg_status = sdio_cis_pkg::ST_SHORT;
          end else begin
            cap_func = 1'b1;
          end
        end else if (head_d[0] == sdio_cis_pkg::EXT_LAN_NODE) begin
          if (len_d < sdio_cis_pkg::MIN_LAN_NODE) begin
            jg_go     = 1'b0;
            jg_status = sdio_cis_pkg::ST_SHORT;
          end
        end else begin
          jg_go = 1'b1;
        end
      end
      default: jg_go = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // captures, phase and result
  always_comb begin
    vendor_d    = chain_start_i ? 16'd0 : vendor_q;
    device_d    = chain_start_i ? 16'd0 : device_q;
    bsize_d     = chain_start_i ? 16'd0 : bsize_q;
    rate_d      = chain_start_i ? 30'd0 : rate_q;
    mbsize_d    = chain_start_i ? 16'd0 : mbsize_q;
    etmo_d      = chain_start_i ? 20'd0 : etmo_q;
    phase_d     = phase_nx;
    emit        = 1'b0;
    emit_status = sdio_cis_pkg::ST_OK;

    if (end_mark) begin
      phase_d = PH_DONE;
      emit    = 1'b1;
    end else if (close_tuple) begin
      if (jg_go) begin
        phase_d = PH_CODE;
        if (cap_manfid) begin
          vendor_d = {head_d[1], head_d[0]};
          device_d = {head_d[3], head_d[2]};
        end
        if (cap_common) begin
          bsize_d = {head_d[2], head_d[1]};
          rate_d  = rate_prod[29:0];
        end
        if (cap_func) begin
          mbsize_d = blk_d;
          etmo_d   = (sdio_version_q == 4'd0) ? {4'd0, default_tmo_q} : tmo_x10;
        end
      end else begin
        phase_d     = PH_DONE;
        emit        = 1'b1;
        emit_status = jg_status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CODE;
      code_q   <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      head_q   <= '0;
      blk_q    <= '0;
      tmo_q    <= '0;
      vendor_q <= '0;
      device_q <= '0;
      bsize_q  <= '0;
      rate_q   <= '0;
      mbsize_q <= '0;
      etmo_q   <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      code_q   <= code_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      head_q   <= head_d;
      blk_q    <= blk_d;
      tmo_q    <= tmo_d;
      vendor_q <= vendor_d;
      device_q <= device_d;
      bsize_q  <= bsize_d;
      rate_q   <= rate_d;
      mbsize_q <= mbsize_d;
      etmo_q   <= etmo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      status_q            <= emit_status;
      vendor_id_o         <= vendor_d;
      device_id_o         <= device_d;
      block_size_o        <= bsize_d;
      max_rate_o          <= rate_d;
      max_block_size_o    <= mbsize_d;
      enable_timeout_ms_o <= etmo_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // ---------------------------------------------------------------------------
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> (phase_q == PH_DONE))
    else $error("result issued without chain ending");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3))
    else $error("undefined status code");

  a_idx_in_tuple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (idx_q < len_q))
    else $error("data index past tuple length");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !chain_start_i && phase_q == PH_DONE) |-> !emit)
    else $error("result after chain end");

endmodule
